// ----- sv/stepseq_pkg.sv -----
// Package for the stepper motor step sequencer.
// Holds register codes, the sequencer state type, the winding and quarter-sine
// tables and the microstep helpers. No dependencies.
package stepseq_pkg;

  localparam int unsigned PosW     = 16;  // position counter width
  localparam int unsigned SineW    = 5;   // quarter-sine ROM index width
  localparam int unsigned LevelW   = 10;  // drive level width
  localparam int unsigned SprW     = 11;  // steps_per_rev width
  localparam int unsigned MicroW   = 6;   // microsteps_per_step width
  localparam int unsigned IntervalW = 24; // step_interval width
  localparam int unsigned StepsW   = 32;  // move and steps-left width
  localparam int unsigned JumpW    = 4;   // ROM stride width, stride is at most 8
  localparam int unsigned DivCntW  = 4;   // one quotient bit per cycle over PosW bits
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned OutDataW = 96;  // 95 bits of fields, padded to bytes

  localparam logic [SprW-1:0]      SprReset      = 11'd200;
  localparam logic [MicroW-1:0]    MicroReset    = 6'd1;
  localparam logic [MicroW-1:0]    MicroMax      = 6'd32;
  localparam logic [IntervalW-1:0] IntervalReset = 24'd1000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_STEPS_PER_REV = 2'd0,
    REG_MICROSTEPS    = 2'd1,
    REG_TWO_WIRE      = 2'd2,
    REG_STEP_INTERVAL = 2'd3
  } cfg_reg_e;

  // Sequencer: idle, or re-deriving step index and phase after a microstep change
  typedef enum logic {
    SEQ_IDLE,
    SEQ_DIVIDE
  } seq_state_e;

  // 8-entry winding table, bit0 A .. bit3 D
  function automatic logic [3:0] winding(input logic [2:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0:    pat = 4'b1000;
      3'd1:    pat = 4'b1010;
      3'd2:    pat = 4'b0010;
      3'd3:    pat = 4'b0110;
      3'd4:    pat = 4'b0100;
      3'd5:    pat = 4'b0101;
      3'd6:    pat = 4'b0001;
      default: pat = 4'b1001;
    endcase
    return pat;
  endfunction

  // Quarter-sine ROM, 32 entries
  function automatic logic [LevelW-1:0] quarter_sine(input logic [SineW-1:0] idx);
    logic [LevelW-1:0] lv;
    case (idx)
      5'd0:  lv = 10'd50;   5'd1:  lv = 10'd100;  5'd2:  lv = 10'd150;  5'd3:  lv = 10'd200;
      5'd4:  lv = 10'd249;  5'd5:  lv = 10'd297;  5'd6:  lv = 10'd345;  5'd7:  lv = 10'd391;
      5'd8:  lv = 10'd437;  5'd9:  lv = 10'd482;  5'd10: lv = 10'd526;  5'd11: lv = 10'd568;
      5'd12: lv = 10'd609;  5'd13: lv = 10'd649;  5'd14: lv = 10'd687;  5'd15: lv = 10'd723;
      5'd16: lv = 10'd758;  5'd17: lv = 10'd791;  5'd18: lv = 10'd822;  5'd19: lv = 10'd851;
      5'd20: lv = 10'd877;  5'd21: lv = 10'd902;  5'd22: lv = 10'd925;  5'd23: lv = 10'd945;
      5'd24: lv = 10'd963;  5'd25: lv = 10'd979;  5'd26: lv = 10'd992;  5'd27: lv = 10'd1003;
      5'd28: lv = 10'd1012; 5'd29: lv = 10'd1018; 5'd30: lv = 10'd1022;
      default: lv = 10'd1023;
    endcase
    return lv;
  endfunction

  // Microstep count as written: zero becomes one, odd above one rounds up, cap at 32
  function automatic logic [MicroW-1:0] norm_micro(input logic [MicroW-1:0] raw);
    logic [MicroW:0] v;
    v = {1'b0, raw};
    if (raw == '0) begin
      v = 7'd1;
    end else if (raw > 6'd1 && raw[0]) begin
      v = v + 7'd1;
    end
    if (v > {1'b0, MicroMax}) begin
      v = {1'b0, MicroMax};
    end
    return v[MicroW-1:0];
  endfunction

  // ROM stride 32 / count, rounded down; only used for counts of 4 and up
  function automatic logic [JumpW-1:0] rom_jump(input logic [MicroW-1:0] m);
    logic [JumpW-1:0] j;
    if (m <= 6'd4) begin
      j = 4'd8;
    end else if (m <= 6'd6) begin
      j = 4'd5;
    end else if (m <= 6'd8) begin
      j = 4'd4;
    end else if (m <= 6'd10) begin
      j = 4'd3;
    end else if (m <= 6'd16) begin
      j = 4'd2;
    end else begin
      j = 4'd1;
    end
    return j;
  endfunction

endpackage

// ----- sv/stepper_motor_step_sequencer.sv -----
// Stepper motor step sequencer: move commands, interval timer, position counter
// and coil drive (full, half and microstep). Depends on stepseq_pkg.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: command, tdata: move_steps
//  m_axis    out  m_axis_tvalid/tready       tdata: result fields (see port)
//  cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One item per cycle while s_axis is ready: the state update and the result are
// one pass of logic from the state registers into the output register.
// Position, step index and microstep phase are counters; a write of
// microsteps_per_step re-derives index and phase from the position with a
// bit-serial divider, with s_axis and cfg not ready meanwhile.
// Reset loads the defaults and clears motion and control state; no clearing pass.
// Output register plus one skid beat: input keeps flowing for one stalled result.
module stepper_motor_step_sequencer
  import stepseq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [StepsW-1:0]   s_axis_tdata,   // [31:0] move_steps
  input  logic                s_axis_tuser,   // [0] command
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] stepped, [1] busy_res, [2] refused, [6:3] coil_pattern, [16:7] level_a,
  // [26:17] level_b, [36:27] level_c, [46:37] level_d, [62:47] position,
  // [94:63] steps_remaining, [95] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [SprW-1:0]      spr_q;
  logic [MicroW-1:0]    micro_q;
  logic [JumpW-1:0]     jump_q;
  logic                 two_wire_q;
  logic [IntervalW-1:0] interval_q;

  // motion state
  logic [PosW-1:0]      pos_q, pos_d;
  logic [1:0]           idx_q, idx_d;     // step index mod 4
  logic [SineW-1:0]     ph_q, ph_d;       // microstep phase
  logic [StepsW-1:0]    left_q, left_d;
  logic                 fwd_q, fwd_d;
  logic [IntervalW-1:0] tick_q, tick_d;
  logic [3:0]           pat_q, pat_d;
  logic [LevelW-1:0]    lv_q [4];
  logic [LevelW-1:0]    lv_d [4];
  logic                 stepped, refused;

  // sequencer and divider
  seq_state_e           state_q, state_d;
  logic [DivCntW-1:0]   cnt_q;
  logic [PosW-1:0]      dvd_q;
  logic [SineW-1:0]     rem_q;
  logic                 quo_q;            // latest quotient bit
  logic [SineW:0]       div_t;
  logic                 div_ge;
  logic [SineW-1:0]     rem_n;
  logic                 div_last;
  logic                 micro_wr;

  // handshakes and output buffer
  logic                 in_fire, cfg_fire;
  logic                 out_q_valid, skid_valid_q;
  logic [OutDataW-1:0]  out_q, skid_q, res_w;

  assign cfg_ready_o   = (state_q == SEQ_IDLE);
  assign s_axis_tready = (state_q == SEQ_IDLE) && !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign micro_wr      = cfg_fire && (cfg_reg_e'(cfg_index_i) == REG_MICROSTEPS);
  assign m_axis_tvalid = out_q_valid;
  assign m_axis_tdata  = out_q;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q      <= SprReset;
      micro_q    <= MicroReset;
      jump_q     <= rom_jump(MicroReset);
      two_wire_q <= 1'b0;
      interval_q <= IntervalReset;
    end else if (cfg_fire) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_STEPS_PER_REV: spr_q <= cfg_data_i[SprW-1:0];
        REG_MICROSTEPS: begin
          micro_q <= norm_micro(cfg_data_i[MicroW-1:0]);
          jump_q  <= rom_jump(norm_micro(cfg_data_i[MicroW-1:0]));
        end
        REG_TWO_WIRE:      two_wire_q <= cfg_data_i[0];
        REG_STEP_INTERVAL: interval_q <= cfg_data_i[IntervalW-1:0];
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state: a microstep write starts a re-derivation of index and phase
  always_comb begin
    state_d  = state_q;
    div_last = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        if (micro_wr) begin
          state_d = SEQ_DIVIDE;
        end
      end
      SEQ_DIVIDE: begin
        if (cnt_q == '1) begin
          div_last = 1'b1;
          state_d  = SEQ_IDLE;
        end
      end
    endcase
  end

  // restoring divide step: one quotient bit per cycle
  assign div_t  = {rem_q, dvd_q[PosW-1]};
  assign div_ge = (div_t >= micro_q);
  assign rem_n  = div_ge ? SineW'(div_t - micro_q) : div_t[SineW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q == SEQ_DIVIDE) begin
      cnt_q <= cnt_q + DivCntW'(1);
    end else begin
      cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SEQ_IDLE) begin
      dvd_q <= pos_q;
      rem_q <= '0;
      quo_q <= 1'b0;
    end else begin
      dvd_q <= {dvd_q[PosW-2:0], 1'b0};
      rem_q <= rem_n;
      quo_q <= div_ge;
    end
  end

  // one item: command load or timer tick, step and coil drive
  always_comb begin
    logic [IntervalW-1:0] period;
    logic [IntervalW:0]   next_tick;
    logic                 fire;
    logic [PosW:0]        wrap;
    logic [PosW:0]        pos_inc;
    logic [3:0]           pat;
    logic [8:0]           rom_prod;
    logic [SineW-1:0]     ridx;
    logic [LevelW-1:0]    rise, fall;
    logic [LevelW-1:0]    lv [4];
    logic [SineW-1:0]     ph_top;

    left_d  = left_q;
    fwd_d   = fwd_q;
    tick_d  = tick_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    ph_d    = ph_q;
    pat_d   = pat_q;
    lv_d    = lv_q;
    stepped = 1'b0;
    refused = 1'b0;

    period    = (interval_q == '0) ? IntervalW'(1) : interval_q;
    next_tick = {1'b0, tick_q} + (IntervalW+1)'(1);
    fire      = (next_tick >= {1'b0, period});

    // revolution fits in 17 bits; an empty revolution acts as one position
    wrap      = (PosW+1)'(spr_q) * (PosW+1)'(micro_q);
    if (wrap == '0) begin
      wrap = (PosW+1)'(1);
    end
    pos_inc   = {1'b0, pos_q} + (PosW+1)'(1);
    ph_top    = SineW'(micro_q - MicroW'(1));
    pat       = '0;
    rom_prod  = '0;
    ridx      = '0;
    rise      = '0;
    fall      = '0;
    lv[0]     = '0;
    lv[1]     = '0;
    lv[2]     = '0;
    lv[3]     = '0;

    if (s_axis_tuser) begin
      // move command
      if (left_q != '0) begin
        refused = 1'b1;
      end else if (s_axis_tdata != '0) begin
        fwd_d  = !s_axis_tdata[StepsW-1];
        left_d = s_axis_tdata[StepsW-1] ? (~s_axis_tdata + StepsW'(1)) : s_axis_tdata;
      end
    end else begin
      tick_d = fire ? '0 : next_tick[IntervalW-1:0];
      if (fire && left_q != '0) begin
        stepped = 1'b1;
        left_d  = left_q - StepsW'(1);
        // position, index and phase move together
        if (fwd_q) begin
          if (pos_inc >= wrap) begin
            pos_d = '0;
            idx_d = '0;
            ph_d  = '0;
          end else begin
            pos_d = pos_inc[PosW-1:0];
            if ({1'b0, ph_q} + 6'd1 == micro_q) begin
              ph_d  = '0;
              idx_d = idx_q + 2'd1;
            end else begin
              ph_d  = ph_q + SineW'(1);
            end
          end
        end else begin
          if (pos_q == '0) begin
            pos_d = PosW'(wrap - (PosW+1)'(1));
            if (spr_q == '0) begin
              idx_d = '0;
              ph_d  = '0;
            end else begin
              idx_d = 2'(spr_q - SprW'(1));
              ph_d  = ph_top;
            end
          end else begin
            pos_d = pos_q - PosW'(1);
            if (ph_q == '0) begin
              ph_d  = ph_top;
              idx_d = idx_q - 2'd1;
            end else begin
              ph_d  = ph_q - SineW'(1);
            end
          end
        end

        // coil drive from the new position
        if (micro_q <= 6'd2) begin
          pat = (micro_q == 6'd1) ? winding({pos_d[1:0], 1'b0}) : winding(pos_d[2:0]);
          if (two_wire_q) begin
            pat = {pat_q[3:2], pat[1:0]};
          end
          pat_d = pat;
        end else begin
          rom_prod = 9'(ph_d) * 9'(jump_q);
          ridx     = rom_prod[SineW-1:0];
          rise     = quarter_sine(ridx);
          fall     = quarter_sine(~ridx);
          case (idx_d)
            2'd0: begin
              lv[0] = fall;
              lv[2] = rise;
            end
            2'd1: begin
              lv[1] = rise;
              lv[2] = fall;
            end
            2'd2: begin
              lv[1] = fall;
              lv[3] = rise;
            end
            default: begin
              lv[0] = rise;
              lv[3] = fall;
            end
          endcase
          lv_d[0] = lv[0];
          lv_d[1] = lv[1];
          if (!two_wire_q) begin
            lv_d[2] = lv[2];
            lv_d[3] = lv[3];
          end
        end
      end
    end
  end

  // result beat from the updated state
  assign res_w = {1'b0, left_d, pos_d, lv_d[3], lv_d[2], lv_d[1], lv_d[0], pat_d,
                  refused, (left_d != '0), stepped};

  // motion state registers; the divider owns index and phase while it runs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      idx_q  <= '0;
      ph_q   <= '0;
      left_q <= '0;
      fwd_q  <= 1'b0;
      tick_q <= '0;
      pat_q  <= '0;
      lv_q   <= '{default: '0};
    end else if (div_last) begin
      idx_q <= {quo_q, div_ge};
      ph_q  <= rem_n;
    end else if (in_fire) begin
      pos_q  <= pos_d;
      idx_q  <= idx_d;
      ph_q   <= ph_d;
      left_q <= left_d;
      fwd_q  <= fwd_d;
      tick_q <= tick_d;
      pat_q  <= pat_d;
      lv_q   <= lv_d;
    end
  end

  // output register and skid beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q_valid  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_q_valid && !m_axis_tready) begin
      if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_q_valid  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_q_valid <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_q_valid && !m_axis_tready) begin
      if (in_fire) begin
        skid_q <= res_w;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_fire) begin
      out_q <= res_w;
    end
  end

`ifndef SYNTHESIS
  // a held skid beat always sits behind a held output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_q_valid)
    else $error("skid beat held without output beat");

  // phase counter stays below the microstep count outside a re-derivation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_IDLE) |-> ({1'b0, ph_q} < micro_q))
    else $error("microstep phase out of range");

  // a microstep write takes s_axis and cfg out of ready as the divide starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    micro_wr |=> !s_axis_tready && !cfg_ready_o)
    else $error("item or write taken during re-derivation");

  // busy flag matches the remaining count, and a refused beat never steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1] == (m_axis_tdata[94:63] != '0))
                      && !(m_axis_tdata[0] && m_axis_tdata[2]))
    else $error("inconsistent result flags");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for stepper_motor_step_sequencer: move and tick beats on the
// input stream, drive results checked against a coil drive model held in a scoreboard class.
// Depends on stepseq_pkg and the sequencer RTL.
module tb_top;
  import stepseq_pkg::*;

  localparam bit          CMD_TICK   = 1'b0;
  localparam bit          CMD_MOVE   = 1'b1;
  localparam int unsigned QUIET_MAX  = 2000;  // cycles with no beat on any channel
  localparam int unsigned SEG_COUNT  = 12;
  localparam int unsigned SEG_ITEMS  = 32;

  // one result beat, unpacked
  typedef struct packed {
    logic              stepped;
    logic              busy;
    logic              refused;
    logic [3:0]        coils;
    logic [LevelW-1:0] lvl_a;
    logic [LevelW-1:0] lvl_b;
    logic [LevelW-1:0] lvl_c;
    logic [LevelW-1:0] lvl_d;
    logic [PosW-1:0]   pos;
    logic [StepsW-1:0] remaining;
  } drive_result_t;

  // Predicts coil drive per accepted beat and checks result beats in order
  class coil_drive_model;
    int unsigned       rev_steps;
    int unsigned       micro_cnt;
    int unsigned       tick_period;
    bit                two_wire_en;
    int unsigned       pos;
    logic [31:0]       steps_left;
    int unsigned       tick_count;
    bit                fwd;
    logic [3:0]        held_pat;
    logic [LevelW-1:0] held_lv [4];
    int unsigned       errors;
    drive_result_t     expected_drive [$];
    logic [3:0]        coil_seq [8] = '{4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1, 4'h9};
    logic [LevelW-1:0] sine_rom [32] = '{
      10'd50,  10'd100, 10'd150, 10'd200, 10'd249, 10'd297, 10'd345, 10'd391,
      10'd437, 10'd482, 10'd526, 10'd568, 10'd609, 10'd649, 10'd687, 10'd723,
      10'd758, 10'd791, 10'd822, 10'd851, 10'd877, 10'd902, 10'd925, 10'd945,
      10'd963, 10'd979, 10'd992, 10'd1003, 10'd1012, 10'd1018, 10'd1022, 10'd1023};

    function void clear();
      rev_steps   = 200;
      micro_cnt   = 1;
      two_wire_en = 1'b0;
      tick_period = 1000;
      pos         = 0;
      steps_left  = '0;
      tick_count  = 0;
      fwd         = 1'b0;
      held_pat    = '0;
      for (int i = 0; i < 4; i++) held_lv[i] = '0;
      errors      = 0;
    endfunction

    function int unsigned pending();
      return expected_drive.size();
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] d);
      int unsigned v;
      case (idx)
        REG_STEPS_PER_REV: rev_steps = 32'(d[SprW-1:0]);
        REG_MICROSTEPS: begin
          v = 32'(d[MicroW-1:0]);
          if (v == 0) v = 1;
          else if (v > 1 && (v % 2) == 1) v = v + 1;
          if (v > 32) v = 32;
          micro_cnt = v;
        end
        REG_TWO_WIRE: two_wire_en = d[0];
        REG_STEP_INTERVAL: tick_period = 32'(d);
        default: ;
      endcase
    endfunction

    // new position -> winding pattern or sine levels
    function void update_drive();
      int unsigned       m, fsi, phase, jump, idx;
      logic [3:0]        pat;
      logic [LevelW-1:0] rise, fall, la, lb, lc, ld;
      m     = (micro_cnt == 0) ? 1 : micro_cnt;
      fsi   = (pos / m) & 32'h7FF;
      phase = (pos % m) & 32'h1F;
      if (m <= 2) begin
        pat = (m == 1) ? coil_seq[(pos & 3) * 2] : coil_seq[pos & 7];
        if (two_wire_en) pat = {held_pat[3:2], pat[1:0]};
        held_pat = pat;
      end else begin
        jump = 32 / m;
        idx  = (phase * jump) & 31;
        rise = sine_rom[idx];
        fall = sine_rom[31 - idx];
        la = '0; lb = '0; lc = '0; ld = '0;
        case (fsi & 3)
          0: begin la = fall; lc = rise; end
          1: begin lb = rise; lc = fall; end
          2: begin lb = fall; ld = rise; end
          default: begin la = rise; ld = fall; end
        endcase
        held_lv[0] = la;
        held_lv[1] = lb;
        if (!two_wire_en) begin
          held_lv[2] = lc;
          held_lv[3] = ld;
        end
      end
    endfunction

    function void predict_item(bit cmd, logic [StepsW-1:0] mv);
      drive_result_t r;
      int unsigned   period, nxt, wrap;
      bit            fire;
      r = '0;
      if (cmd == CMD_MOVE) begin
        if (steps_left != 0) begin
          r.refused = 1'b1;
        end else if (mv != 0) begin
          fwd        = ~mv[31];
          steps_left = mv[31] ? (~mv + 32'd1) : mv;
        end
      end else begin
        period     = (tick_period == 0) ? 1 : tick_period;
        nxt        = tick_count + 1;
        fire       = (nxt >= period);
        tick_count = fire ? 0 : (nxt & 32'hFF_FFFF);
        if (fire && steps_left != 0) begin
          wrap = rev_steps * micro_cnt;
          if (wrap > (1 << PosW)) wrap = 1 << PosW;
          if (wrap == 0) wrap = 1;
          if (fwd) pos = (pos + 1 >= wrap) ? 0 : pos + 1;
          else     pos = (pos == 0) ? wrap - 1 : pos - 1;
          pos = pos & ((1 << PosW) - 1);
          update_drive();
          steps_left = steps_left - 32'd1;
          r.stepped  = 1'b1;
        end
      end
      r.busy      = (steps_left != 0);
      r.coils     = held_pat;
      r.lvl_a     = held_lv[0];
      r.lvl_b     = held_lv[1];
      r.lvl_c     = held_lv[2];
      r.lvl_d     = held_lv[3];
      r.pos       = pos[PosW-1:0];
      r.remaining = steps_left;
      expected_drive.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        if (errors < 10) $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      drive_result_t e;
      if (expected_drive.size() == 0) begin
        if (errors < 10) $display("result beat with nothing expected: %h", d);
        errors++;
        return;
      end
      e = expected_drive.pop_front();
      check_field("stepped",         32'(e.stepped), 32'(d[0]));
      check_field("busy_res",        32'(e.busy),    32'(d[1]));
      check_field("refused",         32'(e.refused), 32'(d[2]));
      check_field("coil_pattern",    32'(e.coils),   32'(d[6:3]));
      check_field("level_a",         32'(e.lvl_a),   32'(d[16:7]));
      check_field("level_b",         32'(e.lvl_b),   32'(d[26:17]));
      check_field("level_c",         32'(e.lvl_c),   32'(d[36:27]));
      check_field("level_d",         32'(e.lvl_d),   32'(d[46:37]));
      check_field("position",        32'(e.pos),     32'(d[62:47]));
      check_field("steps_remaining", e.remaining,    d[94:63]);
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [StepsW-1:0]   s_axis_tdata  = '0;  // [31:0] move_steps
  logic                s_axis_tuser  = 1'b0;  // [0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;  // [0] stepped .. [94:63] steps_remaining
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  coil_drive_model coil_model;
  int unsigned     src_idle = 0;
  int unsigned     snk_idle = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     cfg_spr, cfg_micro, cfg_tw, cfg_interval;

  stepper_motor_step_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle);
  end

  // beat monitor: results are checked before the same-edge input is noted
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) coil_model.check_result(m_axis_tdata);
    if (s_axis_tvalid && s_axis_tready) coil_model.predict_item(s_axis_tuser, s_axis_tdata);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
  end

  // watchdog on a stuck handshake
  initial begin
    while (quiet_cycles < QUIET_MAX) @(posedge clk_i);
    $display("stepper_motor_step_sequencer verification failed");
    $finish;
  end

  // random bits above a register field
  function automatic logic [CfgDataW-1:0] junk_above(int unsigned w);
    return CfgDataW'($urandom & (32'h00FF_FFFF << w));
  endfunction

  // one input beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_item(bit cmd, logic [StepsW-1:0] data);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic put_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    coil_model.write_reg(idx, data);
  endtask

  // drain all results, then write every register
  task automatic apply_config();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (coil_model.pending() != 0) @(posedge clk_i);
    put_reg(REG_STEPS_PER_REV, junk_above(SprW) | CfgDataW'(cfg_spr));
    put_reg(REG_MICROSTEPS, junk_above(MicroW) | CfgDataW'(cfg_micro));
    put_reg(REG_TWO_WIRE, junk_above(1) | CfgDataW'(cfg_tw));
    put_reg(REG_STEP_INTERVAL, CfgDataW'(cfg_interval));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned seg, sent, mag, ticks, period;
    bit          neg;
    coil_model = new();
    coil_model.clear();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full step, one step per tick
    cfg_spr = 200; cfg_micro = 1; cfg_tw = 0; cfg_interval = 1;
    apply_config();
    // zero move keeps the direction, tick has nothing to do
    send_item(CMD_MOVE, 32'h0);
    send_item(CMD_TICK, 32'hFFFF_FFFF);
    // one step back from zero wraps to the top of the revolution
    send_item(CMD_MOVE, 32'hFFFF_FFFF);
    send_item(CMD_TICK, 32'h0);
    // move while busy is refused, forward step wraps to zero
    send_item(CMD_MOVE, 32'd2);
    send_item(CMD_MOVE, 32'h7FFF_FFFF);
    send_item(CMD_TICK, 32'h0);
    send_item(CMD_TICK, 32'h0);

    // half step, backward across zero
    cfg_micro = 2;
    apply_config();
    send_item(CMD_MOVE, -32'sd3);
    repeat (3) send_item(CMD_TICK, $urandom);

    // microstep capped at 32, two-wire, widest revolution
    cfg_spr = 2047; cfg_micro = 63; cfg_tw = 1;
    apply_config();
    send_item(CMD_MOVE, 32'd3);
    repeat (3) send_item(CMD_TICK, $urandom);

    // shrink revolution below the position, zero microstep count, zero interval
    cfg_spr = 10; cfg_micro = 0; cfg_tw = 0; cfg_interval = 0;
    apply_config();
    send_item(CMD_MOVE, -32'sd1);
    send_item(CMD_TICK, 32'h0);

    // zero revolution, uneven microstep count
    cfg_spr = 0; cfg_micro = 5;
    apply_config();
    send_item(CMD_MOVE, 32'd1);
    send_item(CMD_TICK, 32'h0);
    send_item(CMD_MOVE, -32'sd1);
    send_item(CMD_TICK, 32'h0);

    // longest interval: ticks never fire
    cfg_interval = 24'hFF_FFFF;
    apply_config();
    send_item(CMD_MOVE, 32'd2);
    send_item(CMD_TICK, 32'h0);
    send_item(CMD_TICK, 32'h0);

    // random segments, each with its own settings
    for (seg = 0; seg < SEG_COUNT; seg++) begin
      if (seg < 4) begin
        src_idle = 38; snk_idle = 45;
      end else if (seg < 8) begin
        src_idle = 45; snk_idle = 38;
      end else begin
        src_idle = 0; snk_idle = 0;
      end
      case ($urandom_range(0, 4))
        0: cfg_spr = 0;
        1: cfg_spr = 1;
        2: cfg_spr = 2047;
        3: cfg_spr = $urandom_range(1, 2047);
        default: cfg_spr = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 3))
        0: cfg_micro = 1;
        1: cfg_micro = 2;
        default: cfg_micro = $urandom_range(0, 63);
      endcase
      cfg_tw = $urandom_range(0, 1);
      cfg_interval = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      apply_config();
      period = (cfg_interval == 0) ? 1 : cfg_interval;
      sent = 0;
      while (sent < SEG_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: stray tick or a short move
          if ($urandom_range(0, 1) == 0) begin
            send_item(CMD_TICK, $urandom);
          end else begin
            mag = $urandom_range(0, 3);
            send_item(CMD_MOVE, $urandom_range(0, 1) ? -mag : mag);
          end
          sent++;
        end else begin
          // move, maybe a refused move right behind it, then enough ticks to finish
          mag = $urandom_range(1, 8);
          neg = 1'($urandom_range(0, 1));
          send_item(CMD_MOVE, neg ? -mag : mag);
          sent++;
          if ($urandom_range(0, 2) == 0) begin
            send_item(CMD_MOVE, $urandom);
            sent++;
          end
          ticks = mag * period + $urandom_range(0, 3);
          repeat (ticks) begin
            send_item(CMD_TICK, $urandom);
            sent++;
          end
        end
      end
    end

    // most negative move last: its steps never run out
    src_idle = 0; snk_idle = 0;
    cfg_interval = 1;
    apply_config();
    repeat (16) send_item(CMD_TICK, $urandom);
    send_item(CMD_MOVE, 32'h8000_0000);
    repeat (3) send_item(CMD_TICK, $urandom);
    send_item(CMD_MOVE, $urandom);

    s_axis_tvalid <= 1'b0;
    while (coil_model.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (coil_model.errors == 0) begin
      $display("stepper_motor_step_sequencer verification clean");
    end else begin
      $display("stepper_motor_step_sequencer verification failed");
    end
    $finish;
  end

endmodule
